[rtl/core/gsu_pkg.sv]
// Package for the GSM septet unpacker: result word types, escape code and
// the GSM-to-ASCII translation tables as functions.
// No dependencies.
`timescale 1ns / 1ps

package gsu_pkg;

  // Default depth of the queue between the decode front and the output back
  localparam int unsigned QueueDepthDef = 2;

  // Results one octet can cause: two characters and a terminator
  localparam int unsigned MaxResults = 3;

  localparam logic [6:0] EscCode = 7'd27;

  // ASCII codes used by the tables
  localparam logic [6:0] ChSpace = 7'h20;
  localparam logic [6:0] ChAt    = 7'h40;
  localparam logic [6:0] ChDolr  = 7'h24;
  localparam logic [6:0] ChUndr  = 7'h5F;
  localparam logic [6:0] ChLf    = 7'h0A;
  localparam logic [6:0] ChCaret = 7'h5E;
  localparam logic [6:0] ChLBrc  = 7'h7B;
  localparam logic [6:0] ChRBrc  = 7'h7D;
  localparam logic [6:0] ChBslsh = 7'h5C;
  localparam logic [6:0] ChLBrk  = 7'h5B;
  localparam logic [6:0] ChTilde = 7'h7E;
  localparam logic [6:0] ChRBrk  = 7'h5D;
  localparam logic [6:0] ChPipe  = 7'h7C;

  // One result word as it leaves the block
  typedef struct packed {
    logic [6:0] ch;
    logic       term;
    logic       last;
  } slot_t;

  // All results of one octet, packed from slot 0 up
  typedef struct packed {
    slot_t [MaxResults-1:0] slots;
    logic  [1:0]            cnt;
  } entry_t;

  // Default alphabet table
  function automatic logic [6:0] xlat_plain(input logic [6:0] c);
    logic [6:0] a;
    unique case (c) inside
      7'd0:   a = ChAt;
      7'd2:   a = ChDolr;
      7'd17:  a = ChUndr;
      7'd1, [7'd3:7'd9], 7'd11, 7'd12, [7'd14:7'd16], [7'd18:7'd26],
      [7'd28:7'd31], 7'd36, 7'd64, [7'd91:7'd96], [7'd123:7'd127]:
        a = ChSpace;
      default: a = c;
    endcase
    return a;
  endfunction

  // Extension table, used for the septet after an escape
  function automatic logic [6:0] xlat_ext(input logic [6:0] c);
    logic [6:0] a;
    unique case (c)
      7'd10:   a = ChLf;
      7'd20:   a = ChCaret;
      7'd40:   a = ChLBrc;
      7'd41:   a = ChRBrc;
      7'd47:   a = ChBslsh;
      7'd60:   a = ChLBrk;
      7'd61:   a = ChTilde;
      7'd62:   a = ChRBrk;
      7'd64:   a = ChPipe;
      default: a = ChSpace;
    endcase
    return a;
  endfunction

endpackage

[rtl/core/gsm_septet_unpacker_unit.sv]
// GSM septet unpacker top level: packed 7-bit octets in, ASCII words out.
// Depends on gsu_pkg, gsu_front, gsu_queue and gsu_back.
//
// Takes one packed GSM 7-bit octet per cycle while the queue has room and
// returns zero to three words: the septet(s) it completes, translated to
// ASCII through the default or, after an escape septet, the extension table,
// plus a NUL terminator word when tlast marks the message's last octet. The
// front decodes an octet in the cycle it is accepted and places its words in
// a queue of QueueDepth entries; the back sends one word per cycle from its
// output register while the output is ready. Most octets have one word, two
// at a group end or with a terminator, three with both; the input keeps
// accepting while the queue has room. The first word passes through the
// queue and then the back's output register before it is valid on the
// output. tlast on the output marks the last word caused by one octet.
`timescale 1ns / 1ps

module gsm_septet_unpacker_unit #(
  parameter int unsigned QueueDepth = gsu_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] octet
  input  logic [1:0] s_axis_tuser_i,   // [0] msg_start, [1] drop_eighth
  input  logic       s_axis_tlast_i,   // last_octet
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [6:0] ascii_char, [7] zero
  output logic       m_axis_tuser_o,   // is_terminator
  output logic       m_axis_tlast_o    // last_of_run
);
  import gsu_pkg::*;

  logic   q_ready;
  logic   q_push;
  entry_t q_push_entry;
  logic   q_valid;
  logic   q_pop;
  entry_t q_pop_entry;
  slot_t  out_slot;

  // Decode octets into entries
  gsu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .octet_i       (s_axis_tdata_i),
    .msg_start_i   (s_axis_tuser_i[0]),
    .last_octet_i  (s_axis_tlast_i),
    .drop_eighth_i (s_axis_tuser_i[1]),
    .q_ready_i     (q_ready),
    .q_push_o      (q_push),
    .q_entry_o     (q_push_entry)
  );

  // Decouple front and back
  gsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_push_entry),
    .ready_o      (q_ready),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_entry_o  (q_pop_entry)
  );

  // Send words one per cycle while the output is ready
  gsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_pop_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_slot_o  (out_slot)
  );

  assign m_axis_tdata_o = {1'b0, out_slot.ch};
  assign m_axis_tuser_o = out_slot.term;
  assign m_axis_tlast_o = out_slot.last;

endmodule

[rtl/core/gsu_front.sv]
// Decode front of the GSM septet unpacker: rebuilds septets from packed
// octets, tracks escape and builds one queue entry per octet. Uses gsu_pkg.
`timescale 1ns / 1ps

module gsu_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      octet_i,
  input  logic            msg_start_i,
  input  logic            last_octet_i,
  input  logic            drop_eighth_i,
  input  logic            q_ready_i,
  output logic            q_push_o,
  output gsu_pkg::entry_t q_entry_o
);
  import gsu_pkg::*;

  logic [2:0]  group_q, group_d;
  logic [7:0]  prev_q, prev_d;
  logic        esc_q, esc_d;

  logic [2:0]  grp;
  logic [2:0]  k;
  logic [7:0]  prv;
  logic        esc0, esc1, esc2;
  logic [15:0] wide;
  logic [15:0] shifted;
  logic [6:0]  sept0, sept1;
  logic        has1;
  logic        v0, v1;
  logic [6:0]  ch0, ch1;
  logic [1:0]  n;
  logic        fire;
  entry_t      ent;

  assign in_ready_o = q_ready_i;
  assign fire       = in_valid_i && q_ready_i;

  // Rebuild septets, apply escape and pack the results of this octet
  always_comb begin
    grp  = msg_start_i ? 3'd0 : group_q;
    prv  = msg_start_i ? 8'd0 : prev_q;
    esc0 = msg_start_i ? 1'b0 : esc_q;
    k    = (grp > 3'd6) ? 3'd0 : grp;

    wide    = {octet_i, prv};
    shifted = wide >> (4'd8 - {1'b0, k});
    sept0   = shifted[6:0];
    sept1   = octet_i[7:1];
    has1    = (k == 3'd6) && !drop_eighth_i;

    // first septet
    if ((sept0 == EscCode) && !esc0) begin
      v0   = 1'b0;
      ch0  = ChSpace;
      esc1 = 1'b1;
    end else begin
      v0   = 1'b1;
      ch0  = esc0 ? xlat_ext(sept0) : xlat_plain(sept0);
      esc1 = 1'b0;
    end

    // eighth septet of a group
    if (!has1) begin
      v1   = 1'b0;
      ch1  = ChSpace;
      esc2 = esc1;
    end else if ((sept1 == EscCode) && !esc1) begin
      v1   = 1'b0;
      ch1  = ChSpace;
      esc2 = 1'b1;
    end else begin
      v1   = 1'b1;
      ch1  = esc1 ? xlat_ext(sept1) : xlat_plain(sept1);
      esc2 = 1'b0;
    end

    // compact valid results from slot 0 up
    ent = '0;
    n   = 2'd0;
    if (v0) begin
      ent.slots[n] = '{ch: ch0, term: 1'b0, last: 1'b0};
      n = n + 2'd1;
    end
    if (v1) begin
      ent.slots[n] = '{ch: ch1, term: 1'b0, last: 1'b0};
      n = n + 2'd1;
    end
    if (last_octet_i) begin
      ent.slots[n] = '{ch: 7'd0, term: 1'b1, last: 1'b0};
      n = n + 2'd1;
    end
    if (n != 2'd0) begin
      ent.slots[n - 2'd1].last = 1'b1;
    end
    ent.cnt = n;

    // next group state; end of message clears it
    group_d = (k == 3'd6) ? 3'd0 : k + 3'd1;
    prev_d  = octet_i;
    esc_d   = esc2;
    if (last_octet_i) begin
      group_d = 3'd0;
      prev_d  = 8'd0;
      esc_d   = 1'b0;
    end
  end

  assign q_push_o  = fire && (n != 2'd0);
  assign q_entry_o = ent;

  // Hold group state, advance on each accepted octet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= 3'd0;
      prev_q  <= 8'd0;
      esc_q   <= 1'b0;
    end else if (fire) begin
      group_q <= group_d;
      prev_q  <= prev_d;
      esc_q   <= esc_d;
    end
  end

endmodule

[rtl/core/gsu_queue.sv]
// Small queue of decoded entries between the front and the back of the
// GSM septet unpacker. Uses gsu_pkg for the entry type.
`timescale 1ns / 1ps

module gsu_queue #(
  parameter int unsigned Depth = gsu_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gsu_pkg::entry_t push_entry_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output gsu_pkg::entry_t pop_entry_o
);
  import gsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign ready_o     = (count_q != CntW'(Depth));
  assign valid_o     = (count_q != '0);
  assign pop_entry_o = mem_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/core/gsu_back.sv]
// Output back of the GSM septet unpacker: unloads queue entries, sends their
// results from a register, one word per cycle while ready. Uses gsu_pkg.
`timescale 1ns / 1ps

module gsu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  gsu_pkg::entry_t q_entry_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output gsu_pkg::slot_t  out_slot_o
);
  import gsu_pkg::*;

  slot_t [MaxResults-1:0] slots_q;
  logic  [1:0]            cnt_q;
  logic                   take;
  logic                   drained;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_slot_o  = slots_q[0];
  assign take        = out_valid_o && out_ready_i;
  assign drained     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);
  assign q_pop_o     = drained && q_valid_i;

  // Load a new entry once the current one is sent, else shift down on a word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= '0;
      cnt_q   <= 2'd0;
    end else if (q_pop_o) begin
      slots_q <= q_entry_i.slots;
      cnt_q   <= q_entry_i.cnt;
    end else if (take) begin
      slots_q <= {slot_t'('0), slots_q[MaxResults-1:1]};
      cnt_q   <= cnt_q - 2'd1;
    end
  end

endmodule

[tb/tb.sv]
// Self-checking bench for gsm_septet_unpacker_unit: packed GSM octets in,
// ASCII words checked in order against a built-in septet decoder.
// Depends on gsu_pkg and the unpacker RTL.
`timescale 1ns / 1ps

module tb;
  import gsu_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffCycles = 64;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned PhaseOctets = 30;

  // Codes the extension table maps to something other than a space
  localparam logic [6:0] ExtCodes [9] = '{
    7'd10, 7'd20, 7'd40, 7'd41, 7'd47, 7'd60, 7'd61, 7'd62, 7'd64
  };

  // Decodes the octet stream on its own and holds the words still owed
  class gsm_text_tracker;
    logic [2:0]     group_pos;
    logic [7:0]     prev_octet;
    bit             escape_armed;
    slot_t          pending_chars[$];
    int unsigned    mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      group_pos = 3'd0;
      prev_octet = 8'h00;
      escape_armed = 1'b0;
    endfunction

    function logic [6:0] plain_char(logic [6:0] c);
      logic [6:0] a;
      case (c)
        7'd0:  a = ChAt;
        7'd2:  a = ChDolr;
        7'd17: a = ChUndr;
        7'd1, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd11, 7'd12,
        7'd14, 7'd15, 7'd16, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23,
        7'd24, 7'd25, 7'd26, 7'd28, 7'd29, 7'd30, 7'd31, 7'd36, 7'd64,
        7'd91, 7'd92, 7'd93, 7'd94, 7'd95, 7'd96,
        7'd123, 7'd124, 7'd125, 7'd126, 7'd127:
          a = ChSpace;
        default: a = c;
      endcase
      return a;
    endfunction

    function logic [6:0] ext_char(logic [6:0] c);
      logic [6:0] a;
      case (c)
        7'd10:   a = ChLf;
        7'd20:   a = ChCaret;
        7'd40:   a = ChLBrc;
        7'd41:   a = ChRBrc;
        7'd47:   a = ChBslsh;
        7'd60:   a = ChLBrk;
        7'd61:   a = ChTilde;
        7'd62:   a = ChRBrk;
        7'd64:   a = ChPipe;
        default: a = ChSpace;
      endcase
      return a;
    endfunction

    // Rebuild the septets an accepted octet completes and queue their words
    function void take_octet(logic [7:0] octet, bit start, bit last, bit drop);
      int          k;
      int          ns;
      int          before_cnt;
      logic [15:0] s;
      logic [6:0]  sept [2];
      slot_t       w;
      before_cnt = pending_chars.size();
      if (start) clear_state();
      k = int'(group_pos);
      if (k > 6) k = 0;
      s = 16'(octet) << k;
      if (k != 0) s = s | (16'(prev_octet) >> (8 - k));
      sept[0] = s[6:0];
      ns = 1;
      if (k == 6 && !drop) begin
        sept[1] = octet[7:1];
        ns = 2;
      end
      prev_octet = octet;
      group_pos = (k == 6) ? 3'd0 : 3'(k + 1);
      for (int i = 0; i < ns; i++) begin
        if (sept[i] == EscCode && !escape_armed) begin
          escape_armed = 1'b1;
        end else begin
          w.ch = escape_armed ? ext_char(sept[i]) : plain_char(sept[i]);
          w.term = 1'b0;
          w.last = 1'b0;
          escape_armed = 1'b0;
          pending_chars.push_back(w);
        end
      end
      // End of message: NUL word, then forget group and pending escape
      if (last) begin
        w.ch = 7'd0;
        w.term = 1'b1;
        w.last = 1'b0;
        pending_chars.push_back(w);
        clear_state();
      end
      if (pending_chars.size() > before_cnt) begin
        w = pending_chars.pop_back();
        w.last = 1'b1;
        pending_chars.push_back(w);
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    // Compare an accepted output word with the oldest owed word
    function void match_char(logic [7:0] data, logic term, logic last);
      slot_t w;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected word data=%h term=%b last=%b", data, term, last));
      end else begin
        w = pending_chars.pop_front();
        if (data != {1'b0, w.ch} || term != w.term || last != w.last)
          report($sformatf("expected data=%h term=%b last=%b, got data=%h term=%b last=%b",
                           {1'b0, w.ch}, w.term, w.last, data, term, last));
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic [1:0] s_tuser = 2'b00;
  logic       s_tlast = 1'b0;
  logic       m_tready = 1'b0;
  logic       hold_off = 1'b0;
  int         stall_pct = 0;
  int         idle_pct = 0;
  int         octets_sent = 0;
  int         quiet_cycles = 0;

  wire        s_axis_tready_o;
  wire        m_axis_tvalid_o;
  wire [7:0]  m_axis_tdata_o;
  wire        m_axis_tuser_o;
  wire        m_axis_tlast_o;

  gsm_text_tracker tracker;

  gsm_septet_unpacker_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Check accepted words, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_n && m_axis_tvalid_o && m_tready)
      tracker.match_char(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    m_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // End the run when neither side moves a word for too long
  always @(posedge clk_i) begin
    if (!rst_n || (s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one octet after a random gap and hold it until accepted
  task automatic send_octet(input logic [7:0] octet, input bit start, input bit last,
                            input bit drop);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= octet;
    s_tuser <= {drop, start};
    s_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    tracker.take_octet(octet, start, last, drop);
    octets_sent++;
  endtask

  // Pack septets LSB first and send them as one well-formed message
  task automatic send_message(input logic [6:0] septs[$]);
    logic [7:0]  octs[$];
    logic [15:0] acc;
    int          nbits;
    bit          drop;
    bit          last;
    acc = 16'h0000;
    nbits = 0;
    foreach (septs[j]) begin
      acc = acc | (16'(septs[j]) << nbits);
      nbits += 7;
      if (nbits >= 8) begin
        octs.push_back(acc[7:0]);
        acc = acc >> 8;
        nbits -= 8;
      end
    end
    if (nbits > 0) octs.push_back(acc[7:0]);
    foreach (octs[i]) begin
      last = (i == octs.size() - 1);
      // Drop a full final group's padding septet, keep other group ends; else noise
      if (last && (septs.size() % 8 == 7)) drop = 1'b1;
      else if (i % 7 == 6) drop = 1'b0;
      else drop = 1'($urandom_range(1));
      send_octet(octs[i], i == 0, last, drop);
    end
  endtask

  // Random text with escapes and table corner codes mixed in
  task automatic send_random_message();
    logic [6:0] septs[$];
    int         n;
    int         r;
    n = ($urandom_range(3) == 0) ? $urandom_range(24, 13) : $urandom_range(12, 1);
    while (septs.size() < n) begin
      r = $urandom_range(99);
      if (r < 15) begin
        septs.push_back(EscCode);
        if ($urandom_range(1) == 0) septs.push_back(ExtCodes[$urandom_range(8)]);
        else septs.push_back(7'($urandom_range(127)));
      end else if (r < 35) begin
        septs.push_back(7'($urandom_range(36)));
      end else if (r < 40) begin
        septs.push_back(7'($urandom_range(127, 91)));
      end else begin
        septs.push_back(7'($urandom_range(127)));
      end
    end
    // Occasionally leave an escape dangling at the end of the message
    if ($urandom_range(9) == 0) septs.push_back(EscCode);
    send_message(septs);
  endtask

  // Raw octets with arbitrary flags, including broken messages
  task automatic send_noise();
    int cnt;
    cnt = $urandom_range(6, 1);
    repeat (cnt) begin
      send_octet(8'($urandom_range(255)), $urandom_range(4) == 0,
                 $urandom_range(4) == 0, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [6:0] septs[$];
    int         phase_end;
    tracker = new();
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Start and end on one octet
    septs = '{7'd0};
    send_message(septs);
    // Every extension code, escape after escape, a lone escape octet and a
    // dropped padding septet at the final group end
    septs = '{7'd27, 7'd10, 7'd27, 7'd20, 7'd27, 7'd40, 7'd27, 7'd41, 7'd27, 7'd47,
              7'd27, 7'd60, 7'd27, 7'd61, 7'd27, 7'd62, 7'd27, 7'd64, 7'd27, 7'd27,
              7'd2, 7'd17, 7'd0};
    send_message(septs);
    // Pending escape discarded at the end of the message
    septs = '{EscCode};
    send_message(septs);
    // All-ones octet with the drop flag off the group end, then the top bit alone
    send_octet(8'hFF, 1'b1, 1'b0, 1'b1);
    send_octet(8'h80, 1'b0, 1'b1, 1'b0);

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 78 : (p == 3) ? 16 : 0;
      stall_pct <= (p == 2) ? 78 : (p == 3) ? 16 : 0;
      if (p == 0) begin
        // Long receiver hold-off while octets keep coming
        fork
          begin
            hold_off <= 1'b1;
            repeat (HoldOffCycles) @(posedge clk_i);
            hold_off <= 1'b0;
          end
        join_none
      end
      phase_end = octets_sent + PhaseOctets;
      while (octets_sent < phase_end) begin
        if ($urandom_range(9) < 8) send_random_message();
        else send_noise();
      end
    end

    // Drain and settle
    s_tvalid <= 1'b0;
    stall_pct <= 0;
    while (tracker.pending_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_chars.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
